@@ hw/rtl/aest_pkg.sv @@
// ----------------------------------------------------------------------------
// aest_pkg
// Shared types and constants of the absolute encoder speed tracker.
// ----------------------------------------------------------------------------
package aest_pkg;

   localparam int ANGLE_BITS = 12;
   localparam int COUNTS = 1 << ANGLE_BITS;
   localparam int HALF = COUNTS >> 1;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 136;
   localparam int NUM_W = 36;
   localparam int DEN_W = 44;
   localparam int QUO_W = 36;

   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_PERIOD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_PERIOD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REC_THRESH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REC_PERIOD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_INVERT = 3'd4;

   typedef struct packed {
      logic load;
      logic div_start;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic drop;
      logic need_div;
      logic div_done;
   } ctrl_sts_type;

endpackage

@@ hw/rtl/aest_ctrl.sv @@
// ----------------------------------------------------------------------------
// aest_ctrl
// Controller: sequences load, optional division, commit and output handoff.
// ----------------------------------------------------------------------------
module aest_ctrl
   import aest_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {S_IDLE, S_EVAL, S_DIV, S_COMMIT, S_OUT} state_type;

   state_type state_ff, state_in;
   logic      out_ff, out_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_ff;

   always_comb begin
      state_in = state_ff;
      out_in = out_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (sts.drop) begin
               state_in = S_IDLE;
            end else if (sts.need_div) begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            out_in = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               out_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff <= out_in;
      end
   end

endmodule

@@ hw/rtl/aest_div.sv @@
// ----------------------------------------------------------------------------
// aest_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aest_div
   import aest_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [QUO_W-1:0] quo
);

   logic [QUO_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   trial;

   assign quo = q_ff;
   assign done = busy_ff && (cnt_ff == 6'd0);

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {r_ff[DEN_W-1:0], q_ff[QUO_W-1]};
      if (start) begin
         q_in = num;
         r_in = '0;
         d_in = den;
         cnt_in = 6'(QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
         end else begin
            if (trial >= {1'b0, d_ff}) begin
               r_in = trial - {1'b0, d_ff};
               q_in = {q_ff[QUO_W-2:0], 1'b1};
            end else begin
               r_in = trial;
               q_in = {q_ff[QUO_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

endmodule

@@ hw/rtl/aest_dp.sv @@
// ----------------------------------------------------------------------------
// aest_dp
// Datapath: sample registers, tracker state, delta and angle arithmetic.
// ----------------------------------------------------------------------------
module aest_dp
   import aest_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  ctrl_cmd_type          cmd,
   output ctrl_sts_type          sts,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [15:0] aper_ff, sper_ff, rper_ff;
   logic [7:0]  thr_ff;
   logic        inv_ff;

   logic [31:0] now_ff;
   logic        aok_ff, sok_ff;
   logic [ANGLE_BITS-1:0] raw_ff;
   logic [7:0]  stat_ff;

   logic [31:0] last_ff, ptime_ff, total_ff, seq_ff, rtime_ff;
   logic        havep_ff, spok_ff, recd_ff;
   logic [ANGLE_BITS-1:0] pang_ff;
   logic [15:0] hang_ff, erun_ff;
   logic signed [19:0] rpm_ff;
   logic signed [12:0] hdel_ff;
   logic        det_ff, weak_ff, strg_ff, rec_ff, aval_ff;

   logic [31:0] dt;
   logic signed [ANGLE_BITS+1:0] draw, dwrap, dal;
   logic [ANGLE_BITS:0] mag;
   logic [NUM_W-1:0] num;
   logic [DEN_W-1:0] den;
   logic div_done;
   logic [QUO_W-1:0] quo;
   logic speed_upd;
   logic [15:0] erun_next;
   logic [ANGLE_BITS+15:0] ang_prod;

   assign dt = now_ff - ptime_ff;
   assign draw = $signed({2'b00, raw_ff}) - $signed({2'b00, pang_ff});
   always_comb begin
      dwrap = draw;
      if (draw > $signed((ANGLE_BITS+2)'(HALF))) begin
         dwrap = draw - $signed((ANGLE_BITS+2)'(COUNTS));
      end else if (draw < -$signed((ANGLE_BITS+2)'(HALF))) begin
         dwrap = draw + $signed((ANGLE_BITS+2)'(COUNTS));
      end
      dal = inv_ff ? -dwrap : dwrap;
   end
   assign mag = dal[ANGLE_BITS+1] ? (ANGLE_BITS+1)'(0) - dal[ANGLE_BITS:0] : dal[ANGLE_BITS:0];
   assign num = NUM_W'(mag) * NUM_W'(600000);
   assign den = {dt, {ANGLE_BITS{1'b0}}};
   assign speed_upd = havep_ff && (dt >= 32'(sper_ff));
   assign erun_next = (erun_ff == 16'hFFFF) ? erun_ff : erun_ff + 16'd1;
   assign ang_prod = (ANGLE_BITS+16)'(raw_ff) * (ANGLE_BITS+16)'(36000);

   assign sts.drop = (now_ff - last_ff) < 32'(aper_ff);
   assign sts.need_div = aok_ff && speed_upd && (dt != 32'd0);
   assign sts.div_done = div_done;

   aest_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .num(num), .den(den), .done(div_done), .quo(quo)
   );

   assign rsp_tdata = {1'b0, rec_ff, strg_ff, weak_ff, det_ff, erun_ff, seq_ff, total_ff,
                       hdel_ff, rpm_ff, hang_ff, spok_ff, aval_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff <= req_tdata[31:0];
         aok_ff <= req_tdata[32];
         raw_ff <= req_tdata[32+ANGLE_BITS:33];
         sok_ff <= req_tdata[45];
         stat_ff <= req_tdata[53:46];
      end
      if (reset) begin
         aper_ff <= 16'd20;
         sper_ff <= 16'd200;
         thr_ff <= 8'd5;
         rper_ff <= 16'd500;
         inv_ff <= 1'b1;
         last_ff <= '0; ptime_ff <= '0; total_ff <= '0; seq_ff <= '0; rtime_ff <= '0;
         havep_ff <= 1'b0; spok_ff <= 1'b0; recd_ff <= 1'b0;
         pang_ff <= '0; hang_ff <= '0; erun_ff <= '0; rpm_ff <= '0; hdel_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_idx)
               CSR_ANGLE_PERIOD: aper_ff <= csr_wdata;
               CSR_SPEED_PERIOD: sper_ff <= csr_wdata;
               CSR_REC_THRESH:   thr_ff <= csr_wdata[7:0];
               CSR_REC_PERIOD:   rper_ff <= csr_wdata;
               CSR_DIR_INVERT:   inv_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (cmd.commit) begin
            last_ff <= now_ff;
            aval_ff <= aok_ff;
            det_ff <= 1'b0; weak_ff <= 1'b0; strg_ff <= 1'b0; rec_ff <= 1'b0;
            if (!aok_ff) begin
               spok_ff <= 1'b0;
               havep_ff <= 1'b0;
               ptime_ff <= now_ff;
               erun_ff <= erun_next;
               if (erun_next >= {8'd0, thr_ff} &&
                   (!recd_ff || (now_ff - rtime_ff) >= 32'(rper_ff))) begin
                  rec_ff <= 1'b1;
                  rtime_ff <= now_ff;
                  recd_ff <= 1'b1;
               end
            end else begin
               if (sok_ff) begin
                  det_ff <= stat_ff[5]; weak_ff <= stat_ff[4]; strg_ff <= stat_ff[3];
               end
               if (!havep_ff) begin
                  pang_ff <= raw_ff;
                  ptime_ff <= now_ff;
                  havep_ff <= 1'b1;
                  spok_ff <= 1'b0;
                  hdel_ff <= '0;
               end else if (speed_upd) begin
                  hdel_ff <= 13'(dal);
                  total_ff <= total_ff + 32'(dal);
                  if (dt != 32'd0) begin
                     rpm_ff <= dal[ANGLE_BITS+1] ? 20'd0 - quo[19:0] : quo[19:0];
                     spok_ff <= 1'b1;
                     seq_ff <= seq_ff + 32'd1;
                  end else begin
                     spok_ff <= 1'b0;
                  end
                  pang_ff <= raw_ff;
                  ptime_ff <= now_ff;
               end
               hang_ff <= 16'(ang_prod >> ANGLE_BITS);
               erun_ff <= '0;
            end
         end
      end
   end

endmodule

@@ hw/rtl/absolute_encoder_speed_tracker_top.sv @@
// An item that starts a speed update passes the 36-step serial divider for rpm
// before its commit, and the next item is accepted only after its result is taken.
// Other items go from evaluation straight to commit, and a sample that arrives too
// early is dropped at evaluation without a response.
// One item is in flight at a time; the result is held until taken.
// Synchronous active-high reset restores CSR defaults and clears the tracker history.
// ----------------------------------------------------------------------------
// absolute_encoder_speed_tracker_top
// Absolute encoder angle, delta, total and speed tracker.
// ----------------------------------------------------------------------------
module absolute_encoder_speed_tracker_top
   import aest_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // now_ms, angle_read_ok, sensor angle, status_read_ok, status_byte
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // angle good, speed good, angle_centideg, rpm_tenths, delta_counts,
   // total_counts, speed_sequence, consecutive_errors, magnet present,
   // magnet low, magnet high, bus_recover
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   aest_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .sts(sts), .cmd(cmd)
   );

   aest_dp u_dp (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_idx(csr_idx),
      .csr_wdata(csr_wdata), .req_tdata(req_tdata), .cmd(cmd), .sts(sts),
      .rsp_tdata(rsp_tdata)
   );

endmodule
